/* sv/plc_pkg.sv */
// ----------------------------------------------------------------------------
// plc_pkg: shared definitions for the PIN lock controller.
// Holds the PIN length, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

	localparam int PIN_LEN = 5;
	localparam int POS_W   = (PIN_LEN > 1) ? $clog2(PIN_LEN) : 1;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 4;
	localparam int DUTY_W  = 7;
	localparam int DRIVE_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int OUT_W   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD_END = 3'd0,
		REG_PAUSE_END   = 3'd1,
		REG_REVERSE_END = 3'd2,
		REG_ALARM_END   = 3'd3,
		REG_MAX_WRONG   = 3'd4,
		REG_START_CODE  = 3'd5,
		REG_MOTOR_DUTY  = 3'd6
	} reg_idx_t;

	typedef enum logic [DRIVE_W-1:0] {
		DRIVE_OFF     = 2'd0,
		DRIVE_FORWARD = 2'd1,
		DRIVE_REVERSE = 2'd2
	} drive_t;

	localparam logic [BYTE_W-1:0] CMD_OPEN   = 8'd3;
	localparam logic [BYTE_W-1:0] CMD_CHANGE = 8'd4;

	localparam logic [BYTE_W-1:0] RST_FORWARD_END = 8'd15;
	localparam logic [BYTE_W-1:0] RST_PAUSE_END   = 8'd18;
	localparam logic [BYTE_W-1:0] RST_REVERSE_END = 8'd33;
	localparam logic [BYTE_W-1:0] RST_ALARM_END   = 8'd60;
	localparam logic [CNT_W-1:0]  RST_MAX_WRONG   = 4'd3;
	localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd8;
	localparam logic [DUTY_W-1:0] RST_MOTOR_DUTY  = 7'd50;
	localparam logic [DUTY_W-1:0] DUTY_MAX        = 7'd100;

endpackage

`default_nettype wire

/* sv/pin_lock_controller.sv */
// ----------------------------------------------------------------------------
// pin_lock_controller: combination lock with retry lockout.
// An input item passes through one input register and one result register,
// with the state update between them.
// Throughput is one item per cycle while the result side accepts; a new item
// can enter the input register while the previous result still waits.
// Reset returns to PIN setup with default thresholds; the stored PIN is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pin_lock_controller
	import plc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
	input  wire logic [0:0]            s_axis_tuser,  // [0] action
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [0] reply_valid, [1] reply_match, [3:2] motor_drive, [10:4] drive_duty,
	// [11] buzzer_active, [12] busy_running, [15:13] zero
	output logic [OUT_W-1:0]           m_axis_tdata
);

	typedef enum logic [3:0] {
		PH_SETUP_FIRST,
		PH_SETUP_CONFIRM,
		PH_CMD_WAIT,
		PH_ENTRY,
		PH_RETRY_WAIT,
		PH_OPEN_WAIT,
		PH_MOTOR_RUN,
		PH_ALARM_WAIT,
		PH_ALARM_RUN
	} phase_t;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(PIN_LEN - 1);

	logic [BYTE_W-1:0] forward_end_q, pause_end_q, reverse_end_q, alarm_end_q;
	logic [BYTE_W-1:0] start_code_q;
	logic [CNT_W-1:0]  max_wrong_q;
	logic [DUTY_W-1:0] motor_duty_q;

	logic              valid_s1;
	logic              action_s1;
	logic [BYTE_W-1:0] byte_s1;

	phase_t            phase_q, phase_nxt;
	logic [BYTE_W-1:0] stored_pin_q [PIN_LEN];
	logic [BYTE_W-1:0] first_entry_q [PIN_LEN];
	logic [POS_W-1:0]  pos_q, pos_nxt;
	logic              mismatch_q, mismatch_nxt;
	logic              change_q, change_nxt;
	logic [CNT_W-1:0]  open_fail_q, open_fail_nxt;
	logic [CNT_W-1:0]  change_fail_q, change_fail_nxt;
	logic [BYTE_W-1:0] tick_q, tick_nxt;
	logic              half_q, half_nxt;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              step;
	logic              is_byte;
	logic              pin_last;
	logic              write_first;
	logic              copy_pin;
	logic [BYTE_W:0]   tick_adv;
	logic              half_adv;
	logic [BYTE_W-1:0] tick_new;
	logic [DUTY_W-1:0] duty;
	logic [CNT_W-1:0]  fail_cnt;
	logic              rv, rm, buzz, busy;
	drive_t            drive;

	function automatic drive_t motor_stage(input logic [BYTE_W-1:0] t,
		input logic [BYTE_W-1:0] f_end, input logic [BYTE_W-1:0] p_end,
		input logic [BYTE_W-1:0] r_end);
		drive_t d;
		if (t <= f_end) begin
			d = DRIVE_FORWARD;
		end else if (t <= p_end) begin
			d = DRIVE_OFF;
		end else if (t <= r_end) begin
			d = DRIVE_REVERSE;
		end else begin
			d = DRIVE_OFF;
		end
		return d;
	endfunction

	assign cfg_ready     = 1'b1;
	assign step          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign is_byte  = !action_s1;
	assign pin_last = (pos_q == POS_LAST);
	assign duty     = (motor_duty_q > DUTY_MAX) ? DUTY_MAX : motor_duty_q;
	assign fail_cnt = change_q ? change_fail_q : open_fail_q;
	assign half_adv = !half_q;
	assign tick_adv = half_q ? ({1'b0, tick_q} + 9'd1) : {1'b0, tick_q};
	assign tick_new = tick_adv[BYTE_W-1:0];

	always_comb begin
		phase_nxt       = phase_q;
		pos_nxt         = pos_q;
		mismatch_nxt    = mismatch_q;
		change_nxt      = change_q;
		open_fail_nxt   = open_fail_q;
		change_fail_nxt = change_fail_q;
		tick_nxt        = tick_q;
		half_nxt        = half_q;
		write_first     = 1'b0;
		copy_pin        = 1'b0;
		rv              = 1'b0;
		rm              = 1'b0;
		buzz            = 1'b0;
		busy            = 1'b0;
		drive           = DRIVE_OFF;
		case (phase_q)
			PH_SETUP_FIRST: begin
				if (is_byte) begin
					write_first = 1'b1;
					if (pin_last) begin
						pos_nxt      = '0;
						mismatch_nxt = 1'b0;
						phase_nxt    = PH_SETUP_CONFIRM;
					end else begin
						pos_nxt = pos_q + POS_W'(1);
					end
				end
			end
			PH_SETUP_CONFIRM: begin
				if (is_byte) begin
					if (pin_last) begin
						rv           = 1'b1;
						pos_nxt      = '0;
						mismatch_nxt = 1'b0;
						if (mismatch_q || (first_entry_q[pos_q] != byte_s1)) begin
							phase_nxt = PH_SETUP_FIRST;
						end else begin
							rm        = 1'b1;
							copy_pin  = 1'b1;
							phase_nxt = PH_CMD_WAIT;
						end
					end else begin
						pos_nxt = pos_q + POS_W'(1);
						if (first_entry_q[pos_q] != byte_s1) begin
							mismatch_nxt = 1'b1;
						end
					end
				end
			end
			PH_CMD_WAIT: begin
				if (is_byte && (byte_s1 == CMD_OPEN || byte_s1 == CMD_CHANGE)) begin
					change_nxt   = (byte_s1 == CMD_CHANGE);
					pos_nxt      = '0;
					mismatch_nxt = 1'b0;
					phase_nxt    = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				if (is_byte) begin
					if (pin_last) begin
						rv           = 1'b1;
						pos_nxt      = '0;
						mismatch_nxt = 1'b0;
						if (!mismatch_q && (stored_pin_q[pos_q] == byte_s1)) begin
							rm = 1'b1;
							if (change_q) begin
								change_fail_nxt = CNT_W'(1);
								phase_nxt       = PH_SETUP_FIRST;
							end else begin
								open_fail_nxt = CNT_W'(1);
								phase_nxt     = PH_OPEN_WAIT;
							end
						end else if (fail_cnt >= max_wrong_q) begin
							if (change_q) begin
								change_fail_nxt = CNT_W'(1);
							end else begin
								open_fail_nxt = CNT_W'(1);
							end
							phase_nxt = PH_ALARM_WAIT;
						end else begin
							if (change_q) begin
								change_fail_nxt = fail_cnt + CNT_W'(1);
							end else begin
								open_fail_nxt = fail_cnt + CNT_W'(1);
							end
							phase_nxt = PH_RETRY_WAIT;
						end
					end else begin
						pos_nxt = pos_q + POS_W'(1);
						if (stored_pin_q[pos_q] != byte_s1) begin
							mismatch_nxt = 1'b1;
						end
					end
				end
			end
			PH_RETRY_WAIT: begin
				if (is_byte && byte_s1 == start_code_q) begin
					pos_nxt      = '0;
					mismatch_nxt = 1'b0;
					phase_nxt    = PH_ENTRY;
				end
			end
			PH_OPEN_WAIT: begin
				if (is_byte && byte_s1 == start_code_q) begin
					tick_nxt  = '0;
					phase_nxt = PH_MOTOR_RUN;
					drive     = DRIVE_FORWARD;
					busy      = 1'b1;
				end
			end
			PH_MOTOR_RUN: begin
				if (!is_byte) begin
					half_nxt = half_adv;
					if (tick_adv[BYTE_W] || (tick_new > forward_end_q &&
						tick_new > pause_end_q && tick_new > reverse_end_q)) begin
						tick_nxt  = '0;
						phase_nxt = PH_CMD_WAIT;
					end else begin
						tick_nxt = tick_new;
						drive    = motor_stage(tick_new, forward_end_q, pause_end_q,
							reverse_end_q);
						busy     = 1'b1;
					end
				end else begin
					drive = motor_stage(tick_q, forward_end_q, pause_end_q, reverse_end_q);
					busy  = 1'b1;
				end
			end
			PH_ALARM_WAIT: begin
				if (is_byte && byte_s1 == start_code_q) begin
					tick_nxt  = '0;
					phase_nxt = PH_ALARM_RUN;
					buzz      = 1'b1;
					busy      = 1'b1;
				end
			end
			PH_ALARM_RUN: begin
				if (!is_byte) begin
					half_nxt = half_adv;
					if (tick_adv[BYTE_W] || tick_new > alarm_end_q) begin
						tick_nxt  = '0;
						phase_nxt = PH_CMD_WAIT;
					end else begin
						tick_nxt = tick_new;
						buzz     = 1'b1;
						busy     = 1'b1;
					end
				end else begin
					buzz = 1'b1;
					busy = 1'b1;
				end
			end
			default: begin
				phase_nxt = PH_SETUP_FIRST;
				pos_nxt   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_end_q <= RST_FORWARD_END;
			pause_end_q   <= RST_PAUSE_END;
			reverse_end_q <= RST_REVERSE_END;
			alarm_end_q   <= RST_ALARM_END;
			max_wrong_q   <= RST_MAX_WRONG;
			start_code_q  <= RST_START_CODE;
			motor_duty_q  <= RST_MOTOR_DUTY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FORWARD_END: forward_end_q <= cfg_data;
				REG_PAUSE_END:   pause_end_q   <= cfg_data;
				REG_REVERSE_END: reverse_end_q <= cfg_data;
				REG_ALARM_END:   alarm_end_q   <= cfg_data;
				REG_MAX_WRONG:   max_wrong_q   <= cfg_data[CNT_W-1:0];
				REG_START_CODE:  start_code_q  <= cfg_data;
				REG_MOTOR_DUTY:  motor_duty_q  <= cfg_data[DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_q       <= PH_SETUP_FIRST;
			pos_q         <= '0;
			mismatch_q    <= 1'b0;
			change_q      <= 1'b0;
			open_fail_q   <= CNT_W'(1);
			change_fail_q <= CNT_W'(1);
			tick_q        <= '0;
			half_q        <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				phase_q       <= phase_nxt;
				pos_q         <= pos_nxt;
				mismatch_q    <= mismatch_nxt;
				change_q      <= change_nxt;
				open_fail_q   <= open_fail_nxt;
				change_fail_q <= change_fail_nxt;
				tick_q        <= tick_nxt;
				half_q        <= half_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser[0];
			byte_s1   <= s_axis_tdata;
		end
		if (step) begin
			out_data_q <= {3'b000, busy, buzz,
				(drive != DRIVE_OFF) ? duty : DUTY_W'(0), drive, rm, rv};
			if (write_first) begin
				first_entry_q[pos_q] <= byte_s1;
			end
			if (copy_pin) begin
				stored_pin_q <= first_entry_q;
			end
		end
	end

endmodule

`default_nettype wire

/* sim/pin_lock_controller_tb.sv */
// ----------------------------------------------------------------------------
// pin_lock_controller_tb: self-checking bench for the PIN lock controller.
// A queue of key bytes and timer ticks is built against a planning copy of
// the lock, so most items follow the lock's state: PIN setup and confirm,
// open and change commands, good and bad entries, retries, motor and alarm
// runs. A second copy of the lock predicts every result as items are
// accepted, and each result is compared field by field. Both stream sides
// idle at random, and the registers are rewritten between runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pin_lock_controller_tb;
	import plc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [3:0] {
		LK_SETUP_FIRST   = 4'd0,
		LK_SETUP_CONFIRM = 4'd1,
		LK_CMD_WAIT      = 4'd2,
		LK_ENTRY         = 4'd3,
		LK_RETRY_WAIT    = 4'd4,
		LK_OPEN_WAIT     = 4'd5,
		LK_MOTOR_RUN     = 4'd6,
		LK_ALARM_WAIT    = 4'd7,
		LK_ALARM_RUN     = 4'd8
	} lock_phase_t;

	typedef struct packed {
		lock_phase_t                      phase;
		logic [PIN_LEN-1:0][BYTE_W-1:0]   stored_pin;
		logic [PIN_LEN-1:0][BYTE_W-1:0]   first_entry;
		logic [POS_W-1:0]                 digit_pos;
		logic                             mismatch_seen;
		logic                             change_mode;
		logic [CNT_W-1:0]                 open_fails;
		logic [CNT_W-1:0]                 change_fails;
		logic [BYTE_W-1:0]                tick_count;
		logic                             tick_half;
	} lock_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] forward_end;
		logic [BYTE_W-1:0] pause_end;
		logic [BYTE_W-1:0] reverse_end;
		logic [BYTE_W-1:0] alarm_end;
		logic [CNT_W-1:0]  max_wrong;
		logic [BYTE_W-1:0] start_code;
		logic [DUTY_W-1:0] motor_duty;
	} lock_cfg_t;

	typedef struct packed {
		logic [2:0]        spare;
		logic              busy_running;
		logic              buzzer_active;
		logic [DUTY_W-1:0] drive_duty;
		drive_t            motor_drive;
		logic              reply_match;
		logic              reply_valid;
	} lock_reply_t;

	typedef struct packed {
		logic              tick;
		logic [BYTE_W-1:0] rx;
	} key_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;

	lock_cfg_t   lock_cfg;
	lock_state_t planned_lock;
	lock_state_t tracked_lock;
	key_item_t   pending_keys[$];
	lock_reply_t expected_replies[$];
	key_item_t   next_key;
	bit          key_taken = 0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          calm_runs[2] = '{0, 0};
	int          quiet_cycles = 0;
	int          planned_count = 0;
	int          mismatches = 0;
	int          items_accepted = 0;
	int          replies_seen = 0;
	int          replies_matched = 0;
	int          motor_items = 0;
	int          alarm_items = 0;

	pin_lock_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	task automatic advance_lock(inout lock_state_t st, input logic is_tick,
			input logic [BYTE_W-1:0] rx, output lock_reply_t rep);
		int pos;
		int t;
		logic [CNT_W-1:0] fails;
		logic [DUTY_W-1:0] duty;
		drive_t drive;
		logic run_over;
		pos = st.digit_pos;
		rep = '0;
		drive = DRIVE_OFF;
		duty = (lock_cfg.motor_duty > DUTY_MAX) ? DUTY_MAX : lock_cfg.motor_duty;
		fails = st.change_mode ? st.change_fails : st.open_fails;
		t = st.tick_count + st.tick_half;
		run_over = 1'b0;
		case (st.phase)
			LK_SETUP_FIRST: if (!is_tick) begin
				st.first_entry[pos] = rx;
				if (pos == PIN_LEN - 1) begin
					st.digit_pos = '0;
					st.mismatch_seen = 1'b0;
					st.phase = LK_SETUP_CONFIRM;
				end else begin
					st.digit_pos = POS_W'(pos + 1);
				end
			end
			LK_SETUP_CONFIRM: if (!is_tick) begin
				if (st.first_entry[pos] != rx) st.mismatch_seen = 1'b1;
				if (pos == PIN_LEN - 1) begin
					rep.reply_valid = 1'b1;
					rep.reply_match = !st.mismatch_seen;
					if (st.mismatch_seen) begin
						st.phase = LK_SETUP_FIRST;
					end else begin
						st.stored_pin = st.first_entry;
						st.phase = LK_CMD_WAIT;
					end
					st.digit_pos = '0;
					st.mismatch_seen = 1'b0;
				end else begin
					st.digit_pos = POS_W'(pos + 1);
				end
			end
			LK_CMD_WAIT: if (!is_tick && (rx == CMD_OPEN || rx == CMD_CHANGE)) begin
				st.change_mode = (rx == CMD_CHANGE);
				st.digit_pos = '0;
				st.mismatch_seen = 1'b0;
				st.phase = LK_ENTRY;
			end
			LK_ENTRY: if (!is_tick) begin
				if (st.stored_pin[pos] != rx) st.mismatch_seen = 1'b1;
				if (pos == PIN_LEN - 1) begin
					rep.reply_valid = 1'b1;
					if (!st.mismatch_seen) begin
						rep.reply_match = 1'b1;
						fails = CNT_W'(1);
						if (st.change_mode) st.phase = LK_SETUP_FIRST;
						else st.phase = LK_OPEN_WAIT;
					end else if (fails >= lock_cfg.max_wrong) begin
						fails = CNT_W'(1);
						st.phase = LK_ALARM_WAIT;
					end else begin
						fails = fails + 1'b1;
						st.phase = LK_RETRY_WAIT;
					end
					if (st.change_mode) st.change_fails = fails;
					else st.open_fails = fails;
					st.digit_pos = '0;
					st.mismatch_seen = 1'b0;
				end else begin
					st.digit_pos = POS_W'(pos + 1);
				end
			end
			LK_RETRY_WAIT: if (!is_tick && rx == lock_cfg.start_code) begin
				st.digit_pos = '0;
				st.mismatch_seen = 1'b0;
				st.phase = LK_ENTRY;
			end
			LK_OPEN_WAIT: if (!is_tick && rx == lock_cfg.start_code) begin
				st.tick_count = '0;
				st.phase = LK_MOTOR_RUN;
				drive = DRIVE_FORWARD;
				rep.busy_running = 1'b1;
			end
			LK_MOTOR_RUN: begin
				if (is_tick) begin
					st.tick_half = !st.tick_half;
					if (t > 255 || (t > lock_cfg.forward_end && t > lock_cfg.pause_end
							&& t > lock_cfg.reverse_end))
						run_over = 1'b1;
					else
						st.tick_count = BYTE_W'(t);
				end
				if (run_over) begin
					st.tick_count = '0;
					st.phase = LK_CMD_WAIT;
				end else begin
					if (st.tick_count <= lock_cfg.forward_end) drive = DRIVE_FORWARD;
					else if (st.tick_count <= lock_cfg.pause_end) drive = DRIVE_OFF;
					else if (st.tick_count <= lock_cfg.reverse_end) drive = DRIVE_REVERSE;
					rep.busy_running = 1'b1;
				end
			end
			LK_ALARM_WAIT: if (!is_tick && rx == lock_cfg.start_code) begin
				st.tick_count = '0;
				st.phase = LK_ALARM_RUN;
				rep.buzzer_active = 1'b1;
				rep.busy_running = 1'b1;
			end
			LK_ALARM_RUN: begin
				if (is_tick) begin
					st.tick_half = !st.tick_half;
					if (t > 255 || t > lock_cfg.alarm_end) run_over = 1'b1;
					else st.tick_count = BYTE_W'(t);
				end
				if (run_over) begin
					st.tick_count = '0;
					st.phase = LK_CMD_WAIT;
				end else begin
					rep.buzzer_active = 1'b1;
					rep.busy_running = 1'b1;
				end
			end
			default: begin
				st.phase = LK_SETUP_FIRST;
				st.digit_pos = '0;
			end
		endcase
		rep.motor_drive = drive;
		rep.drive_duty = (drive != DRIVE_OFF) ? duty : '0;
	endtask

	function automatic int pick_gap(input int side);
		int r;
		if (calm_runs[side] > 0) begin
			calm_runs[side]--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) calm_runs[side] = $urandom_range(20, 100);
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_item(input logic is_tick, input logic [BYTE_W-1:0] rx);
		lock_state_t before_step;
		lock_reply_t rep;
		before_step = planned_lock;
		advance_lock(planned_lock, is_tick, rx, rep);
		if (planned_lock != before_step || rep != '0) planned_count++;
		pending_keys.push_back({is_tick, rx});
	endtask

	task automatic plan_phase(input int quota);
		int start_count;
		int pos;
		int pick;
		logic is_tick;
		logic [BYTE_W-1:0] rx;
		logic confirm_good;
		logic entry_good;
		start_count = planned_count;
		confirm_good = 1'b1;
		entry_good = 1'b1;
		while (planned_count - start_count < quota || planned_lock.phase == LK_MOTOR_RUN
				|| planned_lock.phase == LK_ALARM_RUN) begin
			pos = planned_lock.digit_pos;
			is_tick = 1'b0;
			rx = BYTE_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			case (planned_lock.phase)
				LK_SETUP_FIRST: is_tick = (pick < 5);
				LK_SETUP_CONFIRM: begin
					if (pos == 0) confirm_good = ($urandom_range(0, 3) != 0);
					is_tick = (pick < 5);
					if (confirm_good) rx = planned_lock.first_entry[pos];
				end
				LK_CMD_WAIT: begin
					if (pick < 40) rx = CMD_OPEN;
					else if (pick < 65) rx = CMD_CHANGE;
					else if (pick < 75) rx = '0;
					else if (pick < 85) is_tick = 1'b1;
				end
				LK_ENTRY: begin
					if (pos == 0) entry_good = ($urandom_range(0, 4) > 1);
					is_tick = (pick < 5);
					if (entry_good) rx = planned_lock.stored_pin[pos];
				end
				LK_RETRY_WAIT, LK_OPEN_WAIT, LK_ALARM_WAIT: begin
					if (pick < 75) rx = lock_cfg.start_code;
					else if (pick < 85) is_tick = 1'b1;
				end
				default: is_tick = (pick < 92);
			endcase
			queue_item(is_tick, rx);
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FORWARD_END: lock_cfg.forward_end = val;
			REG_PAUSE_END:   lock_cfg.pause_end = val;
			REG_REVERSE_END: lock_cfg.reverse_end = val;
			REG_ALARM_END:   lock_cfg.alarm_end = val;
			REG_MAX_WRONG:   lock_cfg.max_wrong = val[CNT_W-1:0];
			REG_START_CODE:  lock_cfg.start_code = val;
			REG_MOTOR_DUTY:  lock_cfg.motor_duty = val[DUTY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [BYTE_W-1:0] fwd, input logic [BYTE_W-1:0] pau,
			input logic [BYTE_W-1:0] rev, input logic [BYTE_W-1:0] alarm,
			input logic [CNT_W-1:0] max_wrong, input logic [BYTE_W-1:0] start,
			input logic [DUTY_W-1:0] duty);
		write_reg(REG_FORWARD_END, fwd);
		write_reg(REG_PAUSE_END, pau);
		write_reg(REG_REVERSE_END, rev);
		write_reg(REG_ALARM_END, alarm);
		write_reg(REG_MAX_WRONG, max_wrong);
		write_reg(REG_START_CODE, start);
		write_reg(REG_MOTOR_DUTY, duty);
	endtask

	task automatic wait_idle;
		do @(posedge clk);
		while (pending_keys.size() != 0 || s_axis_tvalid || expected_replies.size() != 0);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 30)
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			lock_reply_t rep;
			advance_lock(tracked_lock, s_axis_tuser[0], s_axis_tdata, rep);
			expected_replies.push_back(rep);
			key_taken = 1'b1;
			items_accepted++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || key_taken)) begin
			if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap--;
			end else if (pending_keys.size() > 0) begin
				next_key = pending_keys.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_key.rx;
				s_axis_tuser <= next_key.tick;
				send_gap = pick_gap(0);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		key_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			lock_reply_t got;
			lock_reply_t want;
			got = m_axis_tdata;
			if (expected_replies.size() == 0) begin
				mismatches++;
				$display("%0t ns: result expected none, got %h", $time, m_axis_tdata);
			end else begin
				want = expected_replies.pop_front();
				check_field("reply_valid", want.reply_valid, got.reply_valid);
				check_field("reply_match", want.reply_match, got.reply_match);
				check_field("motor_drive", want.motor_drive, got.motor_drive);
				check_field("drive_duty", want.drive_duty, got.drive_duty);
				check_field("buzzer_active", want.buzzer_active, got.buzzer_active);
				check_field("busy_running", want.busy_running, got.busy_running);
				check_field("spare bits", want.spare, got.spare);
				if (want.reply_valid) replies_seen++;
				if (want.reply_match) replies_matched++;
				if (want.motor_drive != DRIVE_OFF) motor_items++;
				if (want.buzzer_active) alarm_items++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("pin_lock_controller test failed");
			$finish;
		end
	end

	initial begin
		int k;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FORWARD_END;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		lock_cfg = {RST_FORWARD_END, RST_PAUSE_END, RST_REVERSE_END, RST_ALARM_END,
			RST_MAX_WRONG, RST_START_CODE, RST_MOTOR_DUTY};
		tracked_lock = '0;
		tracked_lock.phase = LK_SETUP_FIRST;
		tracked_lock.open_fails = CNT_W'(1);
		tracked_lock.change_fails = CNT_W'(1);
		planned_lock = tracked_lock;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Short thresholds and a limit of one wrong entry keep the opening sequence brief.
		apply_settings(8'd1, 8'd2, 8'd3, 8'd1, 4'd1, RST_START_CODE, DUTY_MAX);
		queue_item(1'b1, 8'h00);
		for (k = 0; k < PIN_LEN; k++) queue_item(1'b0, 8'hFF >> k);
		for (k = 0; k < PIN_LEN; k++) queue_item(1'b0, 8'hFF >> k);
		queue_item(1'b0, 8'h00);
		queue_item(1'b0, 8'h07);
		queue_item(1'b1, 8'hFF);
		queue_item(1'b0, CMD_OPEN);
		for (k = 0; k < PIN_LEN; k++)
			queue_item(1'b0, (k == PIN_LEN - 1) ? ~(8'hFF >> k) : (8'hFF >> k));
		queue_item(1'b0, 8'h00);
		queue_item(1'b0, lock_cfg.start_code);
		queue_item(1'b0, 8'hA5);
		while (planned_lock.phase == LK_ALARM_RUN) queue_item(1'b1, 8'h00);
		wait_idle();

		apply_settings(RST_FORWARD_END, RST_PAUSE_END, RST_REVERSE_END, RST_ALARM_END,
			RST_MAX_WRONG, RST_START_CODE, RST_MOTOR_DUTY);
		plan_phase(90);
		wait_idle();

		apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 4'd1, 8'd0, 7'd0);
		plan_phase(60);
		wait_idle();

		apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 4'd15, 8'd255, 7'd127);
		plan_phase(40);
		wait_idle();

		apply_settings(8'd5, 8'd2, 8'd9, 8'd7, 4'd0, CMD_OPEN, DUTY_MAX);
		plan_phase(90);
		wait_idle();

		repeat (2) begin
			apply_settings(BYTE_W'($urandom_range(0, 12)), BYTE_W'($urandom_range(0, 16)),
				BYTE_W'($urandom_range(0, 24)), BYTE_W'($urandom_range(0, 30)),
				CNT_W'($urandom_range(1, 4)), BYTE_W'($urandom_range(0, 255)),
				DUTY_W'($urandom_range(0, 127)));
			plan_phase(70);
			wait_idle();
		end

		repeat (4) @(posedge clk);
		$display("Checked %0d items: %0d PIN replies (%0d matched), %0d motor and %0d alarm items.",
			items_accepted, replies_seen, replies_matched, motor_items, alarm_items);
		$display("Register sets ran from reset values through zero, full-scale and unordered limits.");
		if (mismatches == 0)
			$display("pin_lock_controller test passed");
		else
			$display("pin_lock_controller test failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/plc_pkg.sv
sv/pin_lock_controller.sv
sim/pin_lock_controller_tb.sv
